// ===== design/uudb_pkg.sv =====
// uudb_pkg: shared types and constants for the uudecode body stream core
// no dependencies

package uudb_pkg;

  localparam logic [7:0] CharLf     = 8'h0A;
  localparam logic [7:0] CharCr     = 8'h0D;
  localparam logic [5:0] CharBias   = 6'd32;
  localparam int         GroupBytes = 3;

  // one decoded group handed from the front to the back
  typedef struct packed {
    logic [GroupBytes-1:0][7:0] bytes;   // bytes[0] goes out first
    logic [GroupBytes-1:0]      lasts;   // line_last flag per byte
    logic [1:0]                 count;   // bytes to emit, 1..3
    logic                       is_end;  // single end-of-body item
  } uudb_job_t;

endpackage

// ===== design/uudb_front.sv =====
// uudb_front: accepts characters, tracks line and group state, builds jobs
// depends on uudb_pkg

module uudb_front
  import uudb_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] text_char,
  input  logic       queue_full,
  output logic       job_push,
  output uudb_job_t  job
);

  logic        at_line_start, at_line_start_next;
  logic [5:0]  bytes_left, bytes_left_next;
  logic [1:0]  group_position, group_position_next;
  logic [17:0] sextet_accumulator, sextet_accumulator_next;
  logic        body_finished, body_finished_next;

  logic        accept;
  logic [5:0]  sextet;
  logic [23:0] group;
  logic        emit;
  logic        force_last;
  logic        is_end;
  logic        job_valid;
  logic [1:0]  emit_count;

  assign in_ready = !queue_full;
  assign accept   = in_valid && in_ready;
  assign sextet   = 6'(text_char[5:0] - CharBias);

  // bytes the current group may emit
  assign emit_count = (bytes_left >= 6'd3) ? 2'd3 : bytes_left[1:0];

  // classify the character and compute the next state
  always_comb begin
    at_line_start_next      = at_line_start;
    bytes_left_next         = bytes_left;
    group_position_next     = group_position;
    sextet_accumulator_next = sextet_accumulator;
    body_finished_next      = body_finished;
    group                   = 24'd0;
    emit                    = 1'b0;
    force_last              = 1'b0;
    is_end                  = 1'b0;
    if (body_finished || text_char == CharCr) begin
      // ignored
    end else if (text_char == CharLf) begin
      if (at_line_start) begin
        is_end             = 1'b1;
        body_finished_next = 1'b1;
        at_line_start_next = 1'b0;
      end else begin
        // flush a partial group padded with zero sextets
        case (group_position)
          2'd1:    group = {sextet_accumulator[5:0], 18'd0};
          2'd2:    group = {sextet_accumulator[11:0], 12'd0};
          2'd3:    group = {sextet_accumulator, 6'd0};
          default: group = 24'd0;
        endcase
        emit                    = (group_position != 2'd0);
        force_last              = 1'b1;
        at_line_start_next      = 1'b1;
        bytes_left_next         = 6'd0;
        group_position_next     = 2'd0;
        sextet_accumulator_next = 18'd0;
      end
    end else if (at_line_start) begin
      if (sextet == 6'd0) begin
        is_end             = 1'b1;
        body_finished_next = 1'b1;
        at_line_start_next = 1'b0;
      end else begin
        bytes_left_next         = sextet;
        at_line_start_next      = 1'b0;
        group_position_next     = 2'd0;
        sextet_accumulator_next = 18'd0;
      end
    end else if (group_position == 2'd3) begin
      group                   = {sextet_accumulator, sextet};
      emit                    = 1'b1;
      bytes_left_next         = 6'(bytes_left - {4'd0, emit_count});
      group_position_next     = 2'd0;
      sextet_accumulator_next = 18'd0;
    end else begin
      sextet_accumulator_next = {sextet_accumulator[11:0], sextet};
      group_position_next     = 2'(group_position + 2'd1);
    end
  end

  // job payload
  always_comb begin
    job.is_end = is_end;
    for (int i = 0; i < GroupBytes; i++) begin
      job.bytes[i] = group[23 - 8*i -: 8];
      job.lasts[i] = emit && (emit_count == 2'(i + 1))
                     && (force_last || bytes_left == {4'd0, emit_count});
    end
    if (is_end) begin
      job.bytes = '0;
      job.lasts = '0;
      job.count = 2'd1;
    end else begin
      job.count = emit_count;
    end
  end

  assign job_valid = is_end || (emit && emit_count != 2'd0);
  assign job_push  = accept && job_valid;

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      at_line_start      <= 1'b1;
      bytes_left         <= 6'd0;
      group_position     <= 2'd0;
      sextet_accumulator <= 18'd0;
      body_finished      <= 1'b0;
    end else if (accept) begin
      at_line_start      <= at_line_start_next;
      bytes_left         <= bytes_left_next;
      group_position     <= group_position_next;
      sextet_accumulator <= sextet_accumulator_next;
      body_finished      <= body_finished_next;
    end
  end

endmodule

// ===== design/uudb_fifo.sv =====
// uudb_fifo: small job queue between the front and the back
// depends on uudb_pkg

module uudb_fifo
  import uudb_pkg::*;
#(
  parameter int Depth = 4
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  uudb_job_t push_job,
  output logic      full,
  input  logic      pop,
  output logic      empty,
  output uudb_job_t head_job
);

  localparam int AddrW  = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CountW = $clog2(Depth + 1);

  uudb_job_t          entries [Depth];
  logic [AddrW-1:0]   wr_ptr;
  logic [AddrW-1:0]   rd_ptr;
  logic [CountW-1:0]  count;
  logic               do_push;
  logic               do_pop;

  assign full     = (count == CountW'(Depth));
  assign empty    = (count == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign head_job = entries[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_job;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == AddrW'(Depth - 1)) ? '0 : AddrW'(wr_ptr + 1'b1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == AddrW'(Depth - 1)) ? '0 : AddrW'(rd_ptr + 1'b1);
      end
      if (do_push && !do_pop) begin
        count <= CountW'(count + 1'b1);
      end else if (do_pop && !do_push) begin
        count <= CountW'(count - 1'b1);
      end
    end
  end

endmodule

// ===== design/uudb_back.sv =====
// uudb_back: walks the bytes of each queued job into the output register
// depends on uudb_pkg

module uudb_back
  import uudb_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       queue_empty,
  input  uudb_job_t  head_job,
  output logic       queue_pop,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] data_byte,
  output logic       line_last,
  output logic       end_marker
);

  logic [1:0] byte_idx;
  logic       out_free;
  logic       load;
  logic       job_done;
  logic [7:0] sel_byte;
  logic       sel_last;

  assign out_free  = !out_valid || out_ready;
  assign load      = out_free && !queue_empty;
  assign job_done  = (byte_idx == 2'(head_job.count - 2'd1));
  assign queue_pop = load && job_done;

  // pick the current byte of the head job
  always_comb begin
    case (byte_idx)
      2'd0:    begin sel_byte = head_job.bytes[0]; sel_last = head_job.lasts[0]; end
      2'd1:    begin sel_byte = head_job.bytes[1]; sel_last = head_job.lasts[1]; end
      2'd2:    begin sel_byte = head_job.bytes[2]; sel_last = head_job.lasts[2]; end
      default: begin sel_byte = 8'd0;              sel_last = 1'b0;              end
    endcase
  end

  // byte index and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_idx  <= 2'd0;
      out_valid <= 1'b0;
    end else begin
      if (load) begin
        byte_idx  <= job_done ? 2'd0 : 2'(byte_idx + 2'd1);
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // output payload
  always_ff @(posedge clk) begin
    if (load) begin
      data_byte  <= sel_byte;
      line_last  <= sel_last;
      end_marker <= head_job.is_end;
    end
  end

endmodule

// ===== design/uudecode_body_stream_core.sv =====
// uudecode body stream core: one encoded character per cycle in while the job queue
// has room, one decoded byte per cycle out while out_ready is high. a character
// that yields bytes is queued as a job; the single-byte output register then sends
// the job's bytes one at a time. the job queue absorbs the rate difference.
// reset is synchronous and returns to expecting a line count; after the end of
// the body all input is taken and ignored until the next reset.

module uudecode_body_stream_core
  import uudb_pkg::*;
#(
  parameter int QueueDepth = 4
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] text_char,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] data_byte,
  output logic       line_last,
  output logic       end_marker
);

  uudb_job_t push_job;
  uudb_job_t head_job;
  logic      job_push;
  logic      queue_full;
  logic      queue_empty;
  logic      queue_pop;

  // character classification and group assembly
  uudb_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .text_char  (text_char),
    .queue_full (queue_full),
    .job_push   (job_push),
    .job        (push_job)
  );

  // job queue
  uudb_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (job_push),
    .push_job (push_job),
    .full     (queue_full),
    .pop      (queue_pop),
    .empty    (queue_empty),
    .head_job (head_job)
  );

  // byte serializer
  uudb_back u_back (
    .clk         (clk),
    .rst         (rst),
    .queue_empty (queue_empty),
    .head_job    (head_job),
    .queue_pop   (queue_pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .data_byte   (data_byte),
    .line_last   (line_last),
    .end_marker  (end_marker)
  );

endmodule

// ===== tb/tb_top.sv =====
// testbench for uudecode_body_stream_core: drives encoded body text, predicts decoded bytes
// depends on design/uudb_pkg.sv and design/uudecode_body_stream_core.sv
`timescale 1ns / 100ps

module tb_top;
  import uudb_pkg::*;

  localparam int RandomItems  = 300;
  localparam int HoldCycles   = 150;
  localparam int HoldAfter    = 20;
  localparam int SettleCycles = 20;
  localparam int CycleLimit   = 100000;

  typedef struct {
    logic [7:0] data;
    logic       last;
    logic       fin;
  } dec_item_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] text_char = 8'h00;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] data_byte;
  logic       line_last;
  logic       end_marker;

  logic [7:0] char_q[$];
  dec_item_t  byte_q[$];

  // decoder state as predicted
  logic        want_count = 1'b1;
  logic [5:0]  left_bytes = '0;
  logic [1:0]  held = '0;
  logic [17:0] acc = '0;
  logic        done = 1'b0;

  logic in_taken = 1'b0;
  logic out_taken = 1'b0;
  int   err_count = 0;
  int   out_count = 0;
  int   tx_gap = 0;
  int   rx_wait = 0;
  int   rx_draw;
  logic hold_off = 1'b0;
  logic hold_done = 1'b0;
  int   hold_cnt = 0;
  int   cycles = 0;

  uudecode_body_stream_core u_dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .text_char  (text_char),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .data_byte  (data_byte),
    .line_last  (line_last),
    .end_marker (end_marker)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------- prediction

  // emit up to three bytes of a group, bounded by the line count
  task automatic push_group(logic [23:0] grp, bit flush);
    dec_item_t d;
    for (int i = 0; i < GroupBytes; i++) begin
      if (left_bytes == 0) break;
      left_bytes = left_bytes - 6'd1;
      d.data = grp[23 - 8*i -: 8];
      d.last = (left_bytes == 0) || (flush && i == GroupBytes - 1);
      d.fin  = 1'b0;
      byte_q.push_back(d);
    end
  endtask

  task automatic push_end();
    dec_item_t d;
    d.data = 8'h00;
    d.last = 1'b0;
    d.fin  = 1'b1;
    byte_q.push_back(d);
    done = 1'b1;
    want_count = 1'b0;
  endtask

  task automatic decode_char(logic [7:0] c);
    logic [5:0] s;
    s = c[5:0] - CharBias;
    if (done || c == CharCr) begin
      // nothing happens
    end else if (c == CharLf) begin
      if (want_count) begin
        push_end();
      end else begin
        // flush a partial group padded with zero sextets
        if (held != 0) push_group({6'b0, acc} << (6 * (4 - held)), 1'b1);
        want_count = 1'b1;
        left_bytes = '0;
        held = '0;
        acc = '0;
      end
    end else if (want_count) begin
      if (s == 0) begin
        push_end();
      end else begin
        left_bytes = s;
        want_count = 1'b0;
        held = '0;
        acc = '0;
      end
    end else if (held == 2'd3) begin
      push_group({acc, s}, 1'b0);
      held = '0;
      acc = '0;
    end else begin
      acc = {acc[11:0], s};
      held = held + 2'd1;
    end
  endtask

  // ---------------------------------------------------------------- stimulus

  // character for a sextet; wide picks any of the four aliases
  function automatic logic [7:0] sextet_char(logic [5:0] s, bit wide);
    logic [7:0] c;
    if (wide) begin
      c = {2'($urandom_range(0, 3)), 6'(s + CharBias)};
      if (c == CharLf || c == CharCr) c[6] = 1'b1;
    end else begin
      c = 8'(s) + 8'd32;
    end
    return c;
  endfunction

  task automatic gen_line();
    int  cnt;
    int  nch;
    int  mode;
    int  r;
    bit  wide;
    logic [7:0] c;
    r = $urandom_range(0, 15);
    if (r == 0) cnt = 45;
    else if (r == 1) cnt = 63;
    else cnt = $urandom_range(1, 12);
    mode = $urandom_range(0, 9);
    wide = ($urandom_range(0, 3) == 0);
    nch = 4 * ((cnt + 2) / 3);
    if (mode == 6) nch = $urandom_range(0, nch - 1);
    else if (mode == 7) nch = nch + $urandom_range(1, 6);
    char_q.push_back(sextet_char(6'(cnt), wide));
    for (int i = 0; i < nch; i++) begin
      if ($urandom_range(0, 15) == 0) char_q.push_back(CharCr);
      if (mode >= 8) begin
        // noise: any character except a line end
        c = 8'($urandom_range(0, 255));
        if (c == CharLf) c = 8'hFF;
      end else begin
        c = sextet_char(6'($urandom_range(0, 63)), wide);
      end
      char_q.push_back(c);
    end
    if ($urandom_range(0, 3) == 0) char_q.push_back(CharCr);
    char_q.push_back(CharLf);
  endtask

  function automatic int draw_tx_gap();
    if (char_q.size() > 100 && char_q.size() < 160) return 0;
    return $urandom_range(0, 3);
  endfunction

  function automatic int draw_rx_wait();
    if (out_count >= 120 && out_count < 170) return 0;
    return $urandom_range(0, 3);
  endfunction

  // ---------------------------------------------------------------- checking

  task automatic report(string what, logic [7:0] got, logic [7:0] want);
    $display("mismatch at %0t: %s got %0h expected %0h", $realtime, what, got, want);
    err_count++;
  endtask

  // monitor: predict on accepted input, check accepted output
  always @(posedge clk) begin
    dec_item_t e;
    if (rst) begin
      in_taken  <= 1'b0;
      out_taken <= 1'b0;
    end else begin
      in_taken  <= in_valid && in_ready;
      out_taken <= out_valid && out_ready;
      if (in_valid && in_ready) decode_char(text_char);
      if (out_valid && out_ready) begin
        out_count <= out_count + 1;
        if (byte_q.size() == 0) begin
          report("unexpected item, data_byte", data_byte, 8'h00);
        end else begin
          e = byte_q.pop_front();
          if (data_byte !== e.data) report("data_byte", data_byte, e.data);
          if (line_last !== e.last) report("line_last", 8'(line_last), 8'(e.last));
          if (end_marker !== e.fin) report("end_marker", 8'(end_marker), 8'(e.fin));
        end
      end
    end
  end

  // ---------------------------------------------------------------- driving

  // sender: hold each item until taken, then wait a drawn gap
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      tx_gap <= 0;
    end else if (!in_valid || in_taken) begin
      if (tx_gap != 0) begin
        in_valid <= 1'b0;
        tx_gap <= tx_gap - 1;
      end else if (char_q.size() != 0) begin
        text_char <= char_q.pop_front();
        in_valid <= 1'b1;
        tx_gap <= draw_tx_gap();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver: drawn wait after each item, long hold-off applies on top
  always @(negedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      rx_wait <= 0;
    end else if (out_taken) begin
      rx_draw = draw_rx_wait();
      if (rx_draw == 0) begin
        out_ready <= !hold_off;
        rx_wait <= 0;
      end else begin
        out_ready <= 1'b0;
        rx_wait <= rx_draw - 1;
      end
    end else if (rx_wait != 0) begin
      out_ready <= 1'b0;
      rx_wait <= rx_wait - 1;
    end else begin
      out_ready <= !hold_off;
    end
  end

  // one long receiver stall so the job queue fills and input backs up
  always @(negedge clk) begin
    if (rst) begin
      hold_off <= 1'b0;
      hold_cnt <= 0;
    end else if (hold_off) begin
      if (hold_cnt == 0) hold_off <= 1'b0;
      else hold_cnt <= hold_cnt - 1;
    end else if (!hold_done && out_count >= HoldAfter) begin
      hold_off <= 1'b1;
      hold_done <= 1'b1;
      hold_cnt <= HoldCycles;
    end
  end

  // run limit
  initial begin
    while (cycles < CycleLimit) begin
      @(posedge clk);
      cycles++;
    end
    $display("FAIL uudecode_body_stream_core");
    $finish;
  end

  // ---------------------------------------------------------------- sequence

  initial begin
    int start_len;

    // cr as a count is skipped; all-ones sextets fill a whole group
    char_q.push_back(CharCr);
    char_q.push_back(sextet_char(6'd3, 1'b0));
    repeat (4) char_q.push_back(sextet_char(6'd63, 1'b0));
    char_q.push_back(CharLf);

    // high-bit characters, cr inside a line, partial group flushed at line feed
    char_q.push_back(sextet_char(6'd9, 1'b0));
    char_q.push_back(8'hE0);
    char_q.push_back(8'h9F);
    char_q.push_back(CharCr);
    char_q.push_back(CharLf);

    // excess characters past the line count
    char_q.push_back(sextet_char(6'd1, 1'b0));
    repeat (6) char_q.push_back(sextet_char(6'($urandom_range(0, 63)), 1'b1));
    char_q.push_back(CharLf);

    // short line that ends on a group boundary
    char_q.push_back(sextet_char(6'd6, 1'b0));
    repeat (4) char_q.push_back(sextet_char(6'($urandom_range(0, 63)), 1'b0));
    char_q.push_back(CharLf);

    // random lines
    start_len = char_q.size();
    while (char_q.size() < start_len + RandomItems) gen_line();

    // end of body: zero count or empty line, then input that must be ignored
    if ($urandom_range(0, 1) == 0) char_q.push_back(CharCr);
    if ($urandom_range(0, 1) == 0) char_q.push_back(sextet_char(6'd0, 1'b1));
    else char_q.push_back(CharLf);
    char_q.push_back(CharLf);
    char_q.push_back(sextet_char(6'd45, 1'b0));
    char_q.push_back(8'($urandom_range(0, 255)));
    char_q.push_back(CharLf);

    repeat (4) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    while (char_q.size() != 0 || in_valid) @(posedge clk);
    while (byte_q.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);

    if (err_count == 0) begin
      $display("PASS uudecode_body_stream_core");
    end else begin
      $display("FAIL uudecode_body_stream_core");
    end
    $finish;
  end

endmodule

// ===== files.f =====
design/uudb_pkg.sv
design/uudb_front.sv
design/uudb_fifo.sv
design/uudb_back.sv
design/uudecode_body_stream_core.sv
tb/tb_top.sv
